### design/tphp_pkg.sv
// Package for the text protocol header parser.
// Holds result kinds, status codes and the classified-byte record; no dependencies.
package tphp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_INFO = 3'd0;
    localparam logic [2:0] KIND_MSG  = 3'd1;
    localparam logic [2:0] KIND_PING = 3'd2;
    localparam logic [2:0] KIND_PONG = 3'd3;
    localparam logic [2:0] KIND_OK   = 3'd4;
    localparam logic [2:0] KIND_ERR  = 3'd5;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_NODELIM = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_REJECT  = 3'd4;
    localparam logic [2:0] ST_COUNT   = 3'd5;
    localparam logic [2:0] ST_NUMBER  = 3'd6;
    localparam logic [2:0] ST_LONG    = 3'd7;

    // Byte codes.
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Keywords packed as in the keyword shift register (last byte lowest).
    localparam logic [55:0] KW_INFO    = 56'h494E464F;
    localparam logic [55:0] KW_MSG     = 56'h4D5347;
    localparam logic [55:0] KW_PING    = 56'h50494E47;
    localparam logic [55:0] KW_PONG    = 56'h504F4E47;
    localparam logic [55:0] KW_OK      = 56'h2B4F4B;
    localparam logic [55:0] KW_ERR     = 56'h2D455252;
    localparam logic [55:0] KW_CONNECT = 56'h434F4E4E454354;
    localparam logic [55:0] KW_PUB     = 56'h505542;
    localparam logic [55:0] KW_SUB     = 56'h535542;
    localparam logic [55:0] KW_UNSUB   = 56'h554E535542;

    // Byte class handed from the front end to the back end.
    typedef enum logic [1:0] {
        CLS_SKIP  = 2'd0,
        CLS_TAIL  = 2'd1,
        CLS_END   = 2'd2
    } byte_class_t;

    // Line summary attached to an end-of-line entry.
    typedef struct packed {
        logic        too_long;
        logic        short_line;
        logic        no_delim;
        logic [2:0]  kw_status;
        logic [2:0]  kw_kind;
        logic        is_text;
        logic        is_msg;
        logic [16:0] text_start;
        logic [16:0] text_len;
    } line_sum_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic [16:0] offset;
        line_sum_t   sum;
    } front_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [11:0] span0_start;
        logic [11:0] span0_len;
        logic [11:0] span1_start;
        logic [11:0] span1_len;
        logic [11:0] span2_start;
        logic [11:0] span2_len;
        logic        has_reply;
        logic [31:0] payload_bytes;
        logic [32:0] consume_bytes;
    } result_t;

endpackage

### design/tphp_if.sv
// Valid/ready channel interfaces for the header parser.
// The result fields are declared directly; no dependency on tphp_pkg.
interface tphp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface tphp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [11:0] span0_start;
    logic [11:0] span0_len;
    logic [11:0] span1_start;
    logic [11:0] span1_len;
    logic [11:0] span2_start;
    logic [11:0] span2_len;
    logic        has_reply;
    logic [31:0] payload_bytes;
    logic [32:0] consume_bytes;
    modport source (output valid, output kind, output status, output span0_start,
                    output span0_len, output span1_start, output span1_len,
                    output span2_start, output span2_len, output has_reply,
                    output payload_bytes, output consume_bytes, input ready);
    modport sink   (input valid, input kind, input status, input span0_start,
                    input span0_len, input span1_start, input span1_len,
                    input span2_start, input span2_len, input has_reply,
                    input payload_bytes, input consume_bytes, output ready);
endinterface

### design/tphp_front.sv
// Front end: tracks line offset, keyword and delimiter, classifies each byte.
// Depends on tphp_pkg. Emits one entry per accepted byte (skip, tail byte or end).
module tphp_front #(
    parameter int MAX_LINE = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    output tphp_pkg::front_item_t item
);
    import tphp_pkg::*;

    localparam int OW = 17;
    localparam logic [OW-1:0] MAXL = OW'(MAX_LINE);

    logic [OW-1:0] off_reg;
    logic          over_reg;
    logic [7:0]    held_reg;
    logic          held_valid_reg;
    logic [55:0]   kw_reg;
    logic          dseen_reg;
    logic [OW-1:0] dpos_reg;

    logic          is_lf;
    logic          at_max;
    logic          is_delim;
    line_sum_t     sum;
    logic [OW-1:0] n_len;

    assign is_lf    = (in_byte == CH_LF);
    assign at_max   = (off_reg >= MAXL);
    assign is_delim = (in_byte == CH_SPACE) || (in_byte == CH_CR);
    assign n_len    = off_reg;

    // Keyword lookup and line summary at the line feed.
    always_comb
    begin
        sum = '0;
        sum.too_long   = over_reg;
        sum.short_line = (n_len < OW'(4));
        sum.no_delim   = !dseen_reg;
        sum.kw_status  = ST_UNKNOWN;
        if (dpos_reg == OW'(4) && kw_reg == KW_INFO)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_INFO; sum.is_text = 1'b1;
        end
        else if (dpos_reg == OW'(3) && kw_reg == KW_MSG)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_MSG; sum.is_msg = 1'b1;
        end
        else if (dpos_reg == OW'(4) && kw_reg == KW_PING)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_PING;
        end
        else if (dpos_reg == OW'(4) && kw_reg == KW_PONG)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_PONG;
        end
        else if (dpos_reg == OW'(3) && kw_reg == KW_OK)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_OK;
        end
        else if (dpos_reg == OW'(4) && kw_reg == KW_ERR)
        begin
            sum.kw_status = ST_OK; sum.kw_kind = KIND_ERR; sum.is_text = 1'b1;
        end
        else if ((dpos_reg == OW'(7) && kw_reg == KW_CONNECT)
              || (dpos_reg == OW'(3) && (kw_reg == KW_PUB || kw_reg == KW_SUB))
              || (dpos_reg == OW'(5) && kw_reg == KW_UNSUB))
        begin
            sum.kw_status = ST_REJECT;
        end
        sum.text_start = dpos_reg + OW'(1);
        sum.text_len   = (dpos_reg + OW'(1) <= n_len - OW'(1))
                       ? (n_len - dpos_reg - OW'(2)) : '0;
    end

    // Classification of the accepted byte.
    always_comb
    begin
        item        = '0;
        item.cls    = CLS_SKIP;
        item.data   = held_reg;
        item.offset = off_reg - OW'(1);
        if (is_lf)
        begin
            item.cls = CLS_END;
            item.sum = sum;
        end
        else if (!at_max && held_valid_reg && dseen_reg
                 && (off_reg - OW'(1) > dpos_reg))
        begin
            item.cls = CLS_TAIL;
        end
    end

    // Line tracking registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg        <= '0;
            over_reg       <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            kw_reg         <= '0;
            dseen_reg      <= 1'b0;
            dpos_reg       <= '0;
        end
        else if (in_valid)
        begin
            if (is_lf)
            begin
                off_reg        <= '0;
                over_reg       <= 1'b0;
                held_reg       <= '0;
                held_valid_reg <= 1'b0;
                kw_reg         <= '0;
                dseen_reg      <= 1'b0;
                dpos_reg       <= '0;
            end
            else if (at_max)
            begin
                over_reg <= 1'b1;
            end
            else
            begin
                if (!dseen_reg)
                begin
                    if (is_delim)
                    begin
                        dseen_reg <= 1'b1;
                        dpos_reg  <= off_reg;
                    end
                    else
                    begin
                        kw_reg <= {kw_reg[47:0], in_byte};
                    end
                end
                held_reg       <= in_byte;
                held_valid_reg <= 1'b1;
                off_reg        <= off_reg + OW'(1);
            end
        end
    end

endmodule

### design/tphp_queue.sv
// Short two-entry queue between the front and back ends.
// Depends on tphp_pkg for the entry record.
module tphp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tphp_pkg::front_item_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output tphp_pkg::front_item_t pop_data
);
    import tphp_pkg::*;

    front_item_t mem_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rp_reg];

    // Storage is written without reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### design/tphp_back.sv
// Back end: tokenizes the tail, parses the size and builds the result.
// Depends on tphp_pkg. Holds the finished result in an output register.
module tphp_back #(
    parameter int SIZE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  tphp_pkg::front_item_t q_item,
    output logic                  q_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tphp_pkg::result_t     res
);
    import tphp_pkg::*;

    localparam int AW = SIZE_BITS + 1;
    localparam logic [AW-1:0] MAXV = {1'b0, {SIZE_BITS{1'b1}}};

    logic [2:0]    tcnt_reg;
    logic          in_tok_reg;
    logic [11:0]   st_reg  [3];
    logic [11:0]   len_reg [3];
    logic [AW-1:0] acc_reg [2];
    logic          dig_reg [2];
    logic          stop_reg[2];
    logic          ovr_reg [2];
    logic          out_valid_reg;
    result_t       out_reg;

    logic          can_take;
    logic [7:0]    c;
    logic          is_dig;
    logic [AW-1:0] dval;
    logic [AW+3:0] prod;
    logic [2:0]    k;
    logic          new_tok;
    logic          pos_is0;
    result_t       fin;

    assign can_take  = !out_valid_reg || res_ready;
    assign q_pop     = q_valid && (q_item.cls != CLS_END || can_take);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign c       = q_item.data;
    assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dval    = AW'(c - CH_ZERO);
    assign new_tok = !in_tok_reg;
    assign k       = new_tok ? ((tcnt_reg < 3'd5) ? tcnt_reg : 3'd4) : tcnt_reg - 3'd1;
    assign pos_is0 = new_tok;

    // Next accumulator value for the active size slot.
    always_comb
    begin
        prod = '0;
        if (k == 3'd2)
        begin
            prod = {4'd0, acc_reg[0]} * (AW+4)'(10) + {4'd0, dval};
        end
        else if (k == 3'd3)
        begin
            prod = {4'd0, acc_reg[1]} * (AW+4)'(10) + {4'd0, dval};
        end
    end

    // Result assembly at the line feed.
    always_comb
    begin
        logic          idx;
        logic [AW-1:0] sz;
        logic [33:0]   sz2;
        idx = (tcnt_reg == 3'd4);
        sz  = acc_reg[idx];
        sz2 = 34'(sz) + 34'd2;
        fin = '0;
        if (q_item.sum.too_long)
            fin.status = ST_LONG;
        else if (q_item.sum.short_line)
            fin.status = ST_SHORT;
        else if (q_item.sum.no_delim)
            fin.status = ST_NODELIM;
        else if (q_item.sum.kw_status != ST_OK)
            fin.status = q_item.sum.kw_status;
        else if (q_item.sum.is_text)
        begin
            fin.kind        = q_item.sum.kw_kind;
            fin.span0_start = q_item.sum.text_start[11:0];
            fin.span0_len   = q_item.sum.text_len[11:0];
        end
        else if (!q_item.sum.is_msg)
            fin.kind = q_item.sum.kw_kind;
        else if (tcnt_reg < 3'd3 || tcnt_reg > 3'd4)
            fin.status = ST_COUNT;
        else if (!dig_reg[idx])
            fin.status = ST_NUMBER;
        else if (ovr_reg[idx])
            fin.status = ST_LONG;
        else
        begin
            fin.kind          = KIND_MSG;
            fin.span0_start   = st_reg[0];
            fin.span0_len     = len_reg[0];
            fin.span1_start   = st_reg[1];
            fin.span1_len     = len_reg[1];
            if (tcnt_reg == 3'd4)
            begin
                fin.span2_start = st_reg[2];
                fin.span2_len   = len_reg[2];
                fin.has_reply   = 1'b1;
            end
            fin.payload_bytes = 32'(sz);
            fin.consume_bytes = sz2[32:0];
        end
    end

    // Tokenizer, size parser and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcnt_reg      <= '0;
            in_tok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                st_reg[i]  <= '0;
                len_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                acc_reg[i]  <= '0;
                dig_reg[i]  <= 1'b0;
                stop_reg[i] <= 1'b0;
                ovr_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            // A new result loads the register; a taken result leaves it empty.
            out_valid_reg <= (q_pop && q_item.cls == CLS_END) || (out_valid_reg && !res_ready);
            if (q_pop && q_item.cls == CLS_END)
            begin
                out_reg       <= fin;
                tcnt_reg      <= '0;
                in_tok_reg    <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    st_reg[i]  <= '0;
                    len_reg[i] <= '0;
                end
                for (int i = 0; i < 2; i++)
                begin
                    acc_reg[i]  <= '0;
                    dig_reg[i]  <= 1'b0;
                    stop_reg[i] <= 1'b0;
                    ovr_reg[i]  <= 1'b0;
                end
            end
            else if (q_pop && q_item.cls == CLS_TAIL)
            begin
                if (c == CH_SPACE)
                    in_tok_reg <= 1'b0;
                else
                begin
                    if (new_tok)
                    begin
                        in_tok_reg <= 1'b1;
                        if (tcnt_reg < 3'd5)
                            tcnt_reg <= tcnt_reg + 3'd1;
                    end
                    if (k < 3'd3)
                    begin
                        if (new_tok)
                        begin
                            st_reg[k[1:0]]  <= q_item.offset[11:0];
                            len_reg[k[1:0]] <= 12'd1;
                        end
                        else
                            len_reg[k[1:0]] <= len_reg[k[1:0]] + 12'd1;
                    end
                    if (k == 3'd2 || k == 3'd3)
                    begin
                        if (!stop_reg[k[0]])
                        begin
                            if (is_dig)
                            begin
                                dig_reg[k[0]] <= 1'b1;
                                if (!ovr_reg[k[0]])
                                begin
                                    if (prod > (AW+4)'(MAXV))
                                        ovr_reg[k[0]] <= 1'b1;
                                    else
                                        acc_reg[k[0]] <= prod[AW-1:0];
                                end
                            end
                            else if (!(pos_is0 && c == CH_PLUS))
                                stop_reg[k[0]] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

### design/text_protocol_header_parser.sv
// Header-line parser for a text messaging protocol: one byte per clock in,
// one result per line feed out. A byte is taken every cycle while the
// two-entry queue between the classifier and the tokenizer has room; a
// result is held in an output register so the next line keeps streaming.
// A line feed entry passes the queue and then the output register; a stalled
// result sink stalls input only once the queue fills.
module text_protocol_header_parser #(
    parameter int MAX_LINE  = 4096,
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    tphp_byte_if.sink  in_ch,
    tphp_result_if.source out_ch
);
    import tphp_pkg::*;

    front_item_t f_item;
    front_item_t q_item;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        take;
    logic        r_valid;
    result_t     r;

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && !q_full;

    tphp_front #(.MAX_LINE(MAX_LINE)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(take), .in_byte(in_ch.byte_in),
        .item(f_item)
    );

    tphp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take && f_item.cls != CLS_SKIP),
        .push_data(f_item), .full(q_full), .pop(q_pop), .not_empty(q_valid),
        .pop_data(q_item)
    );

    tphp_back #(.SIZE_BITS(SIZE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .res_valid(r_valid), .res_ready(out_ch.ready), .res(r)
    );

    assign out_ch.valid         = r_valid;
    assign out_ch.kind          = r.kind;
    assign out_ch.status        = r.status;
    assign out_ch.span0_start   = r.span0_start;
    assign out_ch.span0_len     = r.span0_len;
    assign out_ch.span1_start   = r.span1_start;
    assign out_ch.span1_len     = r.span1_len;
    assign out_ch.span2_start   = r.span2_start;
    assign out_ch.span2_len     = r.span2_len;
    assign out_ch.has_reply     = r.has_reply;
    assign out_ch.payload_bytes = r.payload_bytes;
    assign out_ch.consume_bytes = r.consume_bytes;

endmodule
